@@ rtl/rwlq_pkg.sv @@
// package for the reader-writer lock queue
// request codes, outcome codes and cell control types; no dependencies
package rwlq_pkg;
  localparam int QueueDepthDef = 16;
  localparam int IdBitsDef = 6;
  localparam int ResultMax = 16;
  localparam logic [6:0] ReaderMax = 7'd127;

  localparam logic [2:0] REQ_RD = 3'd0;
  localparam logic [2:0] REQ_WR = 3'd1;
  localparam logic [2:0] REQ_TRY_RD = 3'd2;
  localparam logic [2:0] REQ_TRY_WR = 3'd3;
  localparam logic [2:0] REQ_REL_RD = 3'd4;
  localparam logic [2:0] REQ_REL_WR = 3'd5;
  localparam logic [2:0] REQ_CANCEL = 3'd6;

  localparam logic [2:0] OC_GRANTED = 3'd0;
  localparam logic [2:0] OC_QUEUED = 3'd1;
  localparam logic [2:0] OC_REFUSED = 3'd2;
  localparam logic [2:0] OC_WOKEN = 3'd3;
  localparam logic [2:0] OC_CANCELLED = 3'd4;
  localparam logic [2:0] OC_ERROR = 3'd5;
  localparam logic [2:0] OC_RELEASED = 3'd6;

  // control broadcast to every queue cell
  typedef struct packed {
    logic push;   // write into the cell at the tail
    logic shift;  // cells at or above the cut take their upper neighbor
    logic wr_flag;
  } cell_ctl_t;
endpackage

@@ rtl/reader_writer_lock_queue.sv @@
// reader-writer lock with a fifo of waiting requesters, top level
// depends on rwlq_pkg and rwlq_cell
//
// usage: pulse start with in_req_type / in_requester_id while busy is low;
// the request is taken at that edge and busy rises. Results appear on
// out_target_id / out_outcome / out_last for one cycle each, marked by
// out_valid; out_last flags the final result of a request. The receiver
// cannot stall, so results are never held.
// order: a request is decided in the cycle after its transfer, registered
// into the output register, and passes through the delay-line register
// before it reaches the outputs. busy stays high until the final result
// has left, so the next transfer waits for it; a release that frees
// nobody goes through a serve state before the released answer. A release
// or cancel that wakes queued requesters gives up to 16 results per
// request; each wake takes the queue head cell and shifts the whole cell
// chain down one place. A cancel scans the chain combinationally via
// per-cell match flags and a priority pick.
// reset: synchronous active-low rst_n clears the state, reader count, writer
// flag, queue count, valid and held-last flags; queue cells hold no reset value.
module reader_writer_lock_queue import rwlq_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int ID_BITS = IdBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   in_req_type,
  input  logic [5:0]   in_requester_id,
  output logic         out_valid,
  output logic [5:0]   out_target_id,
  output logic [2:0]   out_outcome,
  output logic         out_last
);
  localparam int QW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(ResultMax + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DO = 2'd1;
  localparam logic [1:0] ST_SERVE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [2:0]         type_r, type_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [QW-1:0]      qcnt_r, qcnt_nxt;
  logic [6:0]         rcnt_r, rcnt_nxt;
  logic               wact_r, wact_nxt;
  logic [NW-1:0]      nres_r, nres_nxt;
  logic               ov_r, ov_nxt, ol_r, ol_nxt;
  logic [5:0]         otid_r, otid_nxt;
  logic [2:0]         ooc_r, ooc_nxt;

  cell_ctl_t          ctl;
  logic [IW-1:0]      cut;
  logic [ID_BITS:0]   entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;

  // row of queue cells
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_BITS:0] up;
    if (g == QUEUE_DEPTH - 1) begin : g_top
      assign up = entries[g];
    end else begin : g_mid
      assign up = entries[g+1];
    end
    rwlq_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk(clk), .ctl(ctl),
      .at_tail(qcnt_r == QW'(g)),
      .at_cut(IW'(g) >= cut),
      .push_id(id_r), .up_entry(up), .match_id(id_r),
      .entry(entries[g]), .match(match[g])
    );
  end

  // first valid match for cancel
  logic          hit;
  logic [IW-1:0] hit_pos;
  always_comb begin
    hit = 1'b0;
    hit_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (match[i] && (QW'(i) < qcnt_r)) begin
        hit = 1'b1;
        hit_pos = IW'(i);
      end
    end
  end

  logic [ID_BITS:0] head;
  logic             can_wake;
  assign head = entries[0];
  always_comb begin
    if (head[ID_BITS]) can_wake = (rcnt_r == '0) && !wact_r;
    else can_wake = !wact_r && (rcnt_r < ReaderMax);
  end

  // request sequencer
  always_comb begin
    logic rd_ok, wr_ok, full;
    rd_ok = !wact_r && (qcnt_r == '0) && (rcnt_r < ReaderMax);
    wr_ok = (rcnt_r == '0) && !wact_r;
    full = (qcnt_r >= QW'(QUEUE_DEPTH));
    state_nxt = state_r;
    type_nxt = type_r;
    id_nxt = id_r;
    qcnt_nxt = qcnt_r;
    rcnt_nxt = rcnt_r;
    wact_nxt = wact_r;
    nres_nxt = nres_r;
    ov_nxt = 1'b0;
    ol_nxt = 1'b0;
    otid_nxt = otid_r;
    ooc_nxt = ooc_r;
    ctl = '{push: 1'b0, shift: 1'b0, wr_flag: 1'b0};
    cut = '0;
    case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          type_nxt = in_req_type;
          id_nxt = in_requester_id[ID_BITS-1:0];
          nres_nxt = '0;
          state_nxt = ST_DO;
        end
      end
      ST_DO: begin
        otid_nxt = 6'(id_r);
        ov_nxt = 1'b1;
        ol_nxt = 1'b1;
        state_nxt = ST_IDLE;
        case (type_r)
          REQ_RD, REQ_WR: begin
            if ((type_r == REQ_RD) ? rd_ok : wr_ok) begin
              if (type_r == REQ_RD) rcnt_nxt = rcnt_r + 7'd1;
              else wact_nxt = 1'b1;
              ooc_nxt = OC_GRANTED;
            end else if (!full) begin
              ctl.push = 1'b1;
              ctl.wr_flag = (type_r == REQ_WR);
              cut = IW'(QUEUE_DEPTH - 1);
              qcnt_nxt = qcnt_r + QW'(1);
              ooc_nxt = OC_QUEUED;
            end else begin
              ooc_nxt = OC_ERROR;
            end
          end
          REQ_TRY_RD: begin
            if (rd_ok) begin
              rcnt_nxt = rcnt_r + 7'd1;
              ooc_nxt = OC_GRANTED;
            end else ooc_nxt = OC_REFUSED;
          end
          REQ_TRY_WR: begin
            if (wr_ok) begin
              wact_nxt = 1'b1;
              ooc_nxt = OC_GRANTED;
            end else ooc_nxt = OC_REFUSED;
          end
          REQ_REL_RD, REQ_REL_WR: begin
            if ((type_r == REQ_REL_RD) ? (rcnt_r == '0) : !wact_r) begin
              ooc_nxt = OC_ERROR;
            end else begin
              if (type_r == REQ_REL_RD) rcnt_nxt = rcnt_r - 7'd1;
              else wact_nxt = 1'b0;
              ov_nxt = 1'b0;
              ol_nxt = 1'b0;
              state_nxt = ST_SERVE;
            end
          end
          REQ_CANCEL: begin
            if (hit) begin
              ctl.shift = 1'b1;
              cut = hit_pos;
              qcnt_nxt = qcnt_r - QW'(1);
              ooc_nxt = OC_CANCELLED;
              ol_nxt = 1'b0;
              nres_nxt = NW'(1);
              state_nxt = ST_SERVE;
            end else ooc_nxt = OC_ERROR;
          end
          default: ooc_nxt = OC_ERROR;
        endcase
      end
      ST_SERVE: begin
        // wake one head entry per cycle
        if ((qcnt_r != '0) && can_wake && (nres_r < NW'(ResultMax))) begin
          ctl.shift = 1'b1;
          cut = '0;
          qcnt_nxt = qcnt_r - QW'(1);
          if (head[ID_BITS]) wact_nxt = 1'b1;
          else rcnt_nxt = rcnt_r + 7'd1;
          nres_nxt = nres_r + NW'(1);
          ov_nxt = 1'b1;
          otid_nxt = 6'(head[ID_BITS-1:0]);
          ooc_nxt = OC_WOKEN;
          ol_nxt = head[ID_BITS] || (qcnt_r == QW'(1)) ||
                   (nres_r == NW'(ResultMax - 1)) || (rcnt_r == ReaderMax - 7'd1) ||
                   (entries[1][ID_BITS]);
          if (ol_nxt) state_nxt = ST_IDLE;
        end else begin
          // nothing more to wake: close the run
          state_nxt = ST_IDLE;
          if (nres_r == '0) begin
            ov_nxt = 1'b1;
            ol_nxt = 1'b1;
            otid_nxt = 6'(id_r);
            ooc_nxt = OC_RELEASED;
          end else begin
            // the cancelled result is still pending in the output register
            ov_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      qcnt_r <= '0;
      rcnt_r <= '0;
      wact_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      qcnt_r <= qcnt_nxt;
      rcnt_r <= rcnt_nxt;
      wact_r <= wact_nxt;
      ov_r <= ov_nxt;
    end
    type_r <= type_nxt;
    id_r <= id_nxt;
    nres_r <= nres_nxt;
    ol_r <= ol_nxt;
    otid_r <= otid_nxt;
    ooc_r <= ooc_nxt;
  end

  // a cancel result whose serve finds nothing needs its last flag
  logic hold_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) hold_last_r <= 1'b0;
    else hold_last_r <= (state_r == ST_SERVE) && (state_nxt == ST_IDLE) && !ov_nxt &&
                        (nres_r == NW'(1)) && (type_r == REQ_CANCEL);
  end

  // delay line so cancel followed by no wake still ends with last set
  logic pend_r, plast_r;
  logic [5:0] ptid_r;
  logic [2:0] poc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else pend_r <= ov_r;
    plast_r <= ol_r;
    ptid_r <= otid_r;
    poc_r <= ooc_r;
  end

  assign busy = (state_r != ST_IDLE) || pend_r || ov_r;
  assign out_valid = pend_r;
  assign out_target_id = ptid_r;
  assign out_outcome = poc_r;
  assign out_last = plast_r || (hold_last_r && pend_r);

  // checks
  a_qcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wact_r && (rcnt_r != '0))) else $error("reader and writer together");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised on transfer");
endmodule

@@ rtl/rwlq_cell.sv @@
// one wait queue cell: entry, match flag and shift-down from the upper neighbor
// depends on rwlq_pkg
module rwlq_cell import rwlq_pkg::*; #(
  parameter int ID_BITS = IdBitsDef
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic               at_tail,   // this cell is the tail slot
  input  logic               at_cut,    // this cell is at or above the removal point
  input  logic [ID_BITS-1:0] push_id,
  input  logic [ID_BITS:0]   up_entry,
  input  logic [ID_BITS-1:0] match_id,
  output logic [ID_BITS:0]   entry,
  output logic               match
);
  logic [ID_BITS:0] entry_r, entry_nxt;

  // shift down, or take the pushed entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift && at_cut) begin
      entry_nxt = up_entry;
    end else if (ctl.push && at_tail) begin
      entry_nxt = {ctl.wr_flag, push_id};
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r[ID_BITS-1:0] == match_id);
endmodule
